@@ design/s2lab_pkg.sv @@
// Shared widths, matrix coefficients and the sRGB linearization table for the sRGB to CIELAB pipe.
package s2lab_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int CBRT_TABLE_BITS_DEF = 10;

  // Linear channel and normalized XYZ are unsigned Q24, one included.
  localparam int LIN_Q = 24;
  localparam int LIN_W = LIN_Q + 1;

  // Matrix coefficients and f values are Q20.
  localparam int F_Q = 20;
  localparam int F_W = F_Q + 1;
  localparam int COEF_W = 20;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [LIN_W-1:0] lin_tab_t [256];

  // Row-major sRGB to XYZ matrix with the D65 white folded in, rounded to Q20.
  localparam coef_t COEF [9] = '{
    COEF_W'(((64'd4124564 << 20) + 64'd4752350) / 64'd9504700),
    COEF_W'(((64'd3575761 << 20) + 64'd4752350) / 64'd9504700),
    COEF_W'(((64'd1804375 << 20) + 64'd4752350) / 64'd9504700),
    COEF_W'(((64'd2126729 << 20) + 64'd5000000) / 64'd10000000),
    COEF_W'(((64'd7151522 << 20) + 64'd5000000) / 64'd10000000),
    COEF_W'(((64'd721750 << 20) + 64'd5000000) / 64'd10000000),
    COEF_W'(((64'd193339 << 20) + 64'd5444150) / 64'd10888300),
    COEF_W'(((64'd1191920 << 20) + 64'd5444150) / 64'd10888300),
    COEF_W'(((64'd9503041 << 20) + 64'd5444150) / 64'd10888300)
  };

  // Fifth power of a Q30 value with truncation after every product.
  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] p;
    p = (r * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    return p;
  endfunction

  // One entry of the sRGB decoding curve in Q24.
  function automatic logic [LIN_W-1:0] lin_entry(input int unsigned c);
    logic [63:0] tq;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] x;
    if (c <= 10) begin
      return LIN_W'((((64'(c) * 64'd100) << LIN_Q) + 64'd164730) / 64'd329460);
    end
    tq = (((64'(c) * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    t2 = (tq * tq + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5_q30(mid) <= t2) lo = mid;
      else hi = mid - 64'd1;
    end
    x = (t2 * lo) >> 30;
    return LIN_W'((x + 64'd32) >> 6);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int k = 0; k < 256; k++) begin
      tab[k] = lin_entry(k);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

@@ design/s2lab_lin.sv @@
// First stage: sRGB bytes decoded to linear Q24 through a constant table.
module s2lab_lin (
  input  logic                               clk,
  input  logic                               en,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  output logic [2:0][s2lab_pkg::LIN_W-1:0]   lin
);

  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= s2lab_pkg::LIN_TAB[red];
      lin[1] <= s2lab_pkg::LIN_TAB[green];
      lin[2] <= s2lab_pkg::LIN_TAB[blue];
    end
  end

endmodule

@@ design/s2lab_mat.sv @@
// Two stages of the color matrix: nine products, then row sums rounded and clamped to one.
module s2lab_mat (
  input  logic                               clk,
  input  logic                               en,
  input  logic [2:0][s2lab_pkg::LIN_W-1:0]   lin,
  output logic [2:0][s2lab_pkg::LIN_W-1:0]   xyz
);

  localparam int LW = s2lab_pkg::LIN_W;
  localparam int CW = s2lab_pkg::COEF_W;
  localparam int PW = LW + CW;
  localparam int AW = PW + 2;
  localparam logic [AW-1:0] ROUND = AW'(1) << (s2lab_pkg::F_Q - 1);
  localparam logic [AW-1:0] ONE = AW'(1) << s2lab_pkg::LIN_Q;

  logic [PW-1:0] prod [3][3];
  logic [AW-1:0] acc [3];
  logic [AW-1:0] rnd [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PW'(lin[c]) * PW'(s2lab_pkg::COEF[r*3+c]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(prod[r][0]) + AW'(prod[r][1]) + AW'(prod[r][2]);
      rnd[r] = (acc[r] + ROUND) >> s2lab_pkg::F_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        xyz[r] <= (rnd[r] > ONE) ? LW'(ONE) : rnd[r][LW-1:0];
      end
    end
  end

endmodule

@@ design/s2lab_fn.sv @@
// Three stages of the CIELAB f function: table read, slope product, interpolated sum.
module s2lab_fn #(
  parameter int CBRT_TABLE_BITS = s2lab_pkg::CBRT_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [s2lab_pkg::LIN_W-1:0]   t,
  output logic [s2lab_pkg::F_W-1:0]     f
);

  localparam int LW = s2lab_pkg::LIN_W;
  localparam int FW = s2lab_pkg::F_W;
  localparam int SH = s2lab_pkg::LIN_Q - CBRT_TABLE_BITS;
  localparam int IDX_W = CBRT_TABLE_BITS + 1;
  localparam int FTAB_SIZE = (1 << CBRT_TABLE_BITS) + 1;
  localparam int PRW = FW + SH;
  localparam logic [63:0] FDEN = 64'd3132 << CBRT_TABLE_BITS;
  localparam logic [63:0] FDEN_HALF = FDEN / 2;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FTAB_SIZE - 1);
  localparam logic [PRW:0] HALF = (PRW + 1)'(1) << (SH - 1);

  typedef logic [FW-1:0] ftab_t [FTAB_SIZE];

  // Cube root above (6/29)^3 is floored, the linear segment below is rounded.
  function automatic logic [FW-1:0] f_entry(input int unsigned i);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] num;
    if (64'(i) * 64'd24389 > (64'd216 << CBRT_TABLE_BITS)) begin
      target = 64'(i) << (60 - CBRT_TABLE_BITS);
      lo = 64'd0;
      hi = 64'd1 << s2lab_pkg::F_Q;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid <= target) lo = mid;
        else hi = mid - 64'd1;
      end
      return FW'(lo);
    end
    num = (64'd24389 * 64'(i) + (64'd432 << CBRT_TABLE_BITS)) << s2lab_pkg::F_Q;
    return FW'((num + FDEN_HALF) / FDEN);
  endfunction

  function automatic ftab_t build_ftab();
    ftab_t tab;
    for (int k = 0; k < FTAB_SIZE; k++) begin
      tab[k] = f_entry(k);
    end
    return tab;
  endfunction

  localparam ftab_t FTAB = build_ftab();

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_hi;
  logic [FW-1:0]    e0;
  logic [FW-1:0]    e1;
  logic [SH-1:0]    frac;
  logic [FW-1:0]    diff;
  logic [FW-1:0]    base;
  logic [PRW-1:0]   prod;
  logic [PRW:0]     interp;

  // The input is already clamped to one, so the top index only ever meets a zero fraction.
  assign idx = t[LW-1:SH];
  assign idx_hi = (idx == LAST) ? LAST : idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      e0 <= FTAB[idx];
      e1 <= FTAB[idx_hi];
      frac <= t[SH-1:0];
    end
  end

  assign diff = (e1 > e0) ? e1 - e0 : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PRW'(diff) * PRW'(frac);
      base <= e0;
    end
  end

  assign interp = ((PRW + 1)'(prod) + HALF) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      f <= base + interp[FW-1:0];
    end
  end

endmodule

@@ design/s2lab_lab.sv @@
// Two stages that form L, a and b from the f values, then round and saturate into the output registers.
module s2lab_lab #(
  parameter int FRAC_BITS = s2lab_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [s2lab_pkg::F_W-1:0]     fx,
  input  logic [s2lab_pkg::F_W-1:0]     fy,
  input  logic [s2lab_pkg::F_W-1:0]     fz,
  output logic [14:0]                   lightness,
  output logic signed [15:0]            green_red,
  output logic signed [15:0]            blue_yellow
);

  localparam int FW = s2lab_pkg::F_W;
  localparam int RAW_W = 32;
  localparam int RSH = s2lab_pkg::F_Q - FRAC_BITS;
  localparam logic [RAW_W-1:0] HALF = RAW_W'(1) << (RSH - 1);
  localparam logic signed [RAW_W-1:0] L_OFFSET = RAW_W'(16) << s2lab_pkg::F_Q;
  localparam logic signed [RAW_W-1:0] K116 = 116;
  localparam logic signed [RAW_W-1:0] K500 = 500;
  localparam logic signed [RAW_W-1:0] K200 = 200;
  localparam int LMAX_FULL = 100 << FRAC_BITS;
  localparam int LMAX_INT = (LMAX_FULL > 32767) ? 32767 : LMAX_FULL;
  localparam logic signed [RAW_W-1:0] LMAX = RAW_W'(LMAX_INT);
  localparam logic signed [RAW_W-1:0] S16_MAX = 32767;
  localparam logic signed [RAW_W-1:0] S16_MIN = -32768;

  // Rounds half away from zero.
  function automatic logic signed [RAW_W-1:0] round_shift(input logic signed [RAW_W-1:0] v);
    logic [RAW_W-1:0] mag;
    logic [RAW_W-1:0] r;
    mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
    r = (mag + HALF) >> RSH;
    return v[RAW_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [RAW_W-1:0] v);
    if (v > S16_MAX) return 16'sh7FFF;
    if (v < S16_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [RAW_W-1:0] fx_s;
  logic signed [RAW_W-1:0] fy_s;
  logic signed [RAW_W-1:0] fz_s;
  logic signed [RAW_W-1:0] l_raw;
  logic signed [RAW_W-1:0] a_raw;
  logic signed [RAW_W-1:0] b_raw;
  logic signed [RAW_W-1:0] l_rnd;
  logic signed [RAW_W-1:0] a_rnd;
  logic signed [RAW_W-1:0] b_rnd;

  assign fx_s = $signed({{(RAW_W - FW){1'b0}}, fx});
  assign fy_s = $signed({{(RAW_W - FW){1'b0}}, fy});
  assign fz_s = $signed({{(RAW_W - FW){1'b0}}, fz});

  always_ff @(posedge clk) begin
    if (en) begin
      l_raw <= fy_s * K116 - L_OFFSET;
      a_raw <= (fx_s - fy_s) * K500;
      b_raw <= (fy_s - fz_s) * K200;
    end
  end

  assign l_rnd = round_shift(l_raw);
  assign a_rnd = round_shift(a_raw);
  assign b_rnd = round_shift(b_raw);

  always_ff @(posedge clk) begin
    if (en) begin
      if (l_rnd < 0) begin
        lightness <= '0;
      end else if (l_rnd > LMAX) begin
        lightness <= LMAX[14:0];
      end else begin
        lightness <= l_rnd[14:0];
      end
      green_red <= sat16(a_rnd);
      blue_yellow <= sat16(b_rnd);
    end
  end

endmodule

@@ design/srgb_to_cielab_pixel.sv @@
// Top level of the sRGB to CIELAB (D65) pixel converter.
// An input pixel passes through the decoding, matrix, f function and Lab stages in order;
// its result then waits in the output registers until the receiver takes it.
// Throughput is one pixel per cycle unless stalled; the eight register stages move together
// and all hold while a finished result is stalled, so nothing is lost or repeated.
// Reset clears only the valid bits of the stages; the tables are constants, so the
// block takes pixels from the first cycle after reset.
module srgb_to_cielab_pixel #(
  parameter int FRAC_BITS = s2lab_pkg::FRAC_BITS_DEF,
  parameter int CBRT_TABLE_BITS = s2lab_pkg::CBRT_TABLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 lab_valid,
  input  logic                 lab_stall,
  output logic [14:0]          lightness,
  output logic signed [15:0]   green_red,
  output logic signed [15:0]   blue_yellow
);

  // Stage map: one for the decoding table, two for the matrix, three for the f function,
  // two for the Lab combination and the output rounding.
  localparam int DEPTH = 8;
  localparam int LW = s2lab_pkg::LIN_W;
  localparam int FW = s2lab_pkg::F_W;

  logic                  en;
  logic [DEPTH-1:0]      vld;
  logic [2:0][LW-1:0]    lin;
  logic [2:0][LW-1:0]    xyz;
  logic [2:0][FW-1:0]    fval;

  // The pipe advances unless a result sits in the output registers and the receiver
  // stalls it. Then every stage holds, empty slots included, and the input is stalled.
  assign en = !(vld[DEPTH-1] && lab_stall);
  assign pixel_stall = !en;
  assign lab_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pixel_valid};
    end
  end

  s2lab_lin u_lin (
    .clk   (clk),
    .en    (en),
    .red   (red),
    .green (green),
    .blue  (blue),
    .lin   (lin)
  );

  s2lab_mat u_mat (
    .clk (clk),
    .en  (en),
    .lin (lin),
    .xyz (xyz)
  );

  // One f unit for each of X, Y and Z, each with its own copy of the table.
  for (genvar ch = 0; ch < 3; ch++) begin : g_fn
    s2lab_fn #(
      .CBRT_TABLE_BITS (CBRT_TABLE_BITS)
    ) u_fn (
      .clk (clk),
      .en  (en),
      .t   (xyz[ch]),
      .f   (fval[ch])
    );
  end

  s2lab_lab #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lab (
    .clk         (clk),
    .en          (en),
    .fx          (fval[0]),
    .fy          (fval[1]),
    .fz          (fval[2]),
    .lightness   (lightness),
    .green_red   (green_red),
    .blue_yellow (blue_yellow)
  );

endmodule
